[rtl/core/tkmt_pkg.sv]
// Shared types and constants for the top-k per-key max table.
package tkmt_pkg;
	localparam int unsigned VolW = 31;
	localparam int unsigned KeyW = 32;
	localparam int unsigned DlenW = 8;
	localparam int unsigned CmdW = 2;
	localparam int unsigned KeepW = 5;
	localparam logic [DlenW-1:0] MinDateLen = 8'd5;

	typedef enum logic [CmdW-1:0] {
		CMD_INSERT = 2'd0,
		CMD_QUERY  = 2'd1,
		CMD_CLEAR  = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	localparam logic CfgMinVolume = 1'b0;
	localparam logic CfgKeepCount = 1'b1;

	typedef struct packed {
		cmd_t             command;
		logic [VolW-1:0]  volume;
		logic [KeyW-1:0]  period_key;
		logic             date_ok;
	} tkmt_item_t;
endpackage

[rtl/core/top_k_per_key_max_table.sv]
// Top-k per-key max table: queries and key updates scan every slot; a new entry also runs the
// eviction check, which rescans all slots once per dropped entry; clear and early reject skip the scan.
// One item at a time, set by the slot scan in the back end (one slot per cycle); the next item
// is taken in the cycle after a result is loaded, and a two-entry queue takes items meanwhile.
// Reset empties the table, sets min_volume to 0 and keep_count to 16, and clears the output.
// Top level: configuration registers, front queue and table engine.
module top_k_per_key_max_table #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [30:0] volume,
	input  logic [31:0] period_key,
	input  logic [7:0]  date_length,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        answer,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);
	import tkmt_pkg::*;

	logic [VolW-1:0]  min_volume_q;
	logic [KeepW-1:0] keep_count_q;
	logic             q_valid, q_pop;
	tkmt_item_t       q_item;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_volume_q <= '0;
			keep_count_q <= KeepW'(16);
		end else if (cfg_valid) begin
			if (cfg_index == CfgMinVolume) min_volume_q <= cfg_data[VolW-1:0];
			else keep_count_q <= cfg_data[KeepW-1:0];
		end
	end

	tkmt_front u_front (
		.clk, .arst_n, .in_valid, .in_stall, .command, .volume, .period_key,
		.date_length, .q_valid, .q_pop, .q_item
	);

	tkmt_back #(.CAPACITY(CAPACITY)) u_back (
		.clk, .arst_n, .q_valid, .q_pop, .q_item,
		.min_volume(min_volume_q), .keep_count(keep_count_q),
		.out_valid, .out_stall, .answer
	);

`ifndef ASSERT_OFF
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(answer))
		else $error("result dropped under stall");
	a_cfg_reg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid && cfg_index == CfgKeepCount |=> keep_count_q == $past(cfg_data[KeepW-1:0]))
		else $error("keep_count write lost");
`endif
endmodule

[rtl/core/tkmt_front.sv]
// Front end: accepts items, classifies them, and queues them for the table engine.
module tkmt_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [1:0]                command,
	input  logic [tkmt_pkg::VolW-1:0] volume,
	input  logic [tkmt_pkg::KeyW-1:0] period_key,
	input  logic [tkmt_pkg::DlenW-1:0] date_length,
	output logic                      q_valid,
	input  logic                      q_pop,
	output tkmt_pkg::tkmt_item_t      q_item
);
	import tkmt_pkg::*;

	// two-entry queue
	tkmt_item_t mem_q [2];
	logic       rd_q, wr_q;
	logic [1:0] cnt_q;
	logic       push;
	tkmt_item_t it;

	always_comb begin
		it.command = cmd_t'(command);
		it.volume = volume;
		it.period_key = period_key;
		it.date_ok = (date_length >= MinDateLen);
	end

	assign in_stall = (cnt_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign q_valid = (cnt_q != 2'd0);
	assign q_item = mem_q[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_q <= 1'b0;
			wr_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (q_pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, q_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= it;
	end
endmodule

[rtl/core/tkmt_back.sv]
// Back end: table slots, sequencer for match, min search and eviction, result register.
module tkmt_back #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	output logic                       q_pop,
	input  tkmt_pkg::tkmt_item_t       q_item,
	input  logic [tkmt_pkg::VolW-1:0]  min_volume,
	input  logic [tkmt_pkg::KeepW-1:0] keep_count,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic                       answer
);
	import tkmt_pkg::*;

	localparam int unsigned IdxW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned CntW = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_MATCH, ST_SCAN, ST_PLACE, ST_EVICT, ST_DONE
	} st_t;

	st_t                st_q;
	tkmt_item_t         cur_q;
	logic [CAPACITY-1:0] valid_q;
	logic [KeyW-1:0]    key_q [CAPACITY];
	logic [VolW-1:0]    vol_q [CAPACITY];
	logic               res_q;
	logic               ans_q;
	logic               outv_q;
	logic [IdxW-1:0]    scan_q;
	logic               minf_q;
	logic [IdxW-1:0]    mini_q;
	logic [VolW-1:0]    minv_q;
	logic               hit_q;
	logic [IdxW-1:0]    hiti_q;
	logic               dup_q;
	logic               freef_q;
	logic [IdxW-1:0]    freei_q;
	logic [CntW-1:0]    count_q;
	logic [CntW-1:0]    limit;

	assign answer = ans_q;
	assign out_valid = outv_q;
	assign q_pop = (st_q == ST_IDLE) && q_valid;
	assign limit = ({{(32-KeepW){1'b0}}, keep_count} >= CAPACITY) ? CntW'(CAPACITY)
		: CntW'(keep_count);

	// one slot per cycle: key match, equal volume, first free, minimum
	logic               sv;
	logic               last;
	assign sv = valid_q[scan_q];
	assign last = (scan_q == IdxW'(CAPACITY - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			valid_q <= '0;
			outv_q <= 1'b0;
			res_q <= 1'b0;
			ans_q <= 1'b0;
			scan_q <= '0;
			minf_q <= 1'b0;
			hit_q <= 1'b0;
			dup_q <= 1'b0;
			freef_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (outv_q && !out_stall && st_q != ST_DONE) outv_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (q_valid) begin
						cur_q <= q_item;
						scan_q <= '0;
						minf_q <= 1'b0;
						hit_q <= 1'b0;
						dup_q <= 1'b0;
						freef_q <= 1'b0;
						st_q <= ST_MATCH;
					end
				end
				ST_MATCH: begin
					unique case (cur_q.command)
						CMD_CLEAR: begin
							valid_q <= '0;
							count_q <= '0;
							res_q <= 1'b0;
							st_q <= ST_DONE;
						end
						CMD_NONE: begin
							res_q <= 1'b0;
							st_q <= ST_DONE;
						end
						CMD_INSERT: begin
							if (cur_q.volume <= min_volume || !cur_q.date_ok) begin
								res_q <= 1'b0;
								st_q <= ST_DONE;
							end else st_q <= ST_SCAN;
						end
						default: st_q <= ST_SCAN;
					endcase
				end
				ST_SCAN: begin
					if (sv) begin
						if (key_q[scan_q] == cur_q.period_key && !hit_q) begin
							hit_q <= 1'b1;
							hiti_q <= scan_q;
						end
						if (vol_q[scan_q] == cur_q.volume) dup_q <= 1'b1;
						if (!minf_q || vol_q[scan_q] < minv_q) begin
							minf_q <= 1'b1;
							mini_q <= scan_q;
							minv_q <= vol_q[scan_q];
						end
					end else if (!freef_q) begin
						freef_q <= 1'b1;
						freei_q <= scan_q;
					end
					if (last) st_q <= ST_PLACE;
					else scan_q <= scan_q + 1'b1;
				end
				ST_PLACE: begin
					if (cur_q.command == CMD_QUERY) begin
						res_q <= minf_q && (minv_q <= cur_q.volume);
						st_q <= ST_DONE;
					end else if (hit_q) begin
						if (cur_q.volume > vol_q[hiti_q]) begin
							vol_q[hiti_q] <= cur_q.volume;
							res_q <= 1'b1;
						end else res_q <= 1'b0;
						st_q <= ST_DONE;
					end else if (dup_q) begin
						res_q <= 1'b0;
						st_q <= ST_DONE;
					end else begin
						res_q <= 1'b1;
						if (freef_q) begin
							valid_q[freei_q] <= 1'b1;
							key_q[freei_q] <= cur_q.period_key;
							vol_q[freei_q] <= cur_q.volume;
							count_q <= count_q + 1'b1;
						end else if (minf_q && cur_q.volume > minv_q) begin
							key_q[mini_q] <= cur_q.period_key;
							vol_q[mini_q] <= cur_q.volume;
						end
						scan_q <= '0;
						minf_q <= 1'b0;
						st_q <= ST_EVICT;
					end
				end
				ST_EVICT: begin
					// rescan for the minimum, drop it, repeat while over the limit
					if (count_q <= limit) st_q <= ST_DONE;
					else begin
						if (sv && (!minf_q || vol_q[scan_q] < minv_q)) begin
							minf_q <= 1'b1;
							mini_q <= scan_q;
							minv_q <= vol_q[scan_q];
						end
						if (last) begin
							if (sv && (!minf_q || vol_q[scan_q] < minv_q))
								valid_q[scan_q] <= 1'b0;
							else
								valid_q[mini_q] <= 1'b0;
							count_q <= count_q - 1'b1;
							scan_q <= '0;
							minf_q <= 1'b0;
						end else scan_q <= scan_q + 1'b1;
					end
				end
				ST_DONE: begin
					// hold until the output register is free
					if (!outv_q || !out_stall) begin
						outv_q <= 1'b1;
						ans_q <= res_q;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[test/tb_top_k_per_key_max_table.sv]
// Testbench for the top-k per-key max table: scoreboard prediction with directed and random stimulus.
module tb_top_k_per_key_max_table;
	timeunit 1ns;
	timeprecision 1ps;
	import tkmt_pkg::*;

	localparam int Cap = 16;

	class table_scoreboard;
		bit [30:0] floor_vol;
		bit [4:0] keep_lim;
		bit held[Cap];
		bit [31:0] held_key[Cap];
		bit [30:0] held_vol[Cap];
		bit answers[$];
		int errors;

		function new();
			floor_vol = 0;
			keep_lim = 16;
			errors = 0;
			foreach (held[i]) held[i] = 0;
		endfunction

		function int smallest_slot();
			int best;
			best = -1;
			for (int i = 0; i < Cap; i++)
				if (held[i] && (best < 0 || held_vol[i] < held_vol[best])) best = i;
			return best;
		endfunction

		function bit insert_entry(bit [30:0] v, bit [31:0] k, bit [7:0] dl);
			int slot;
			int n;
			int lim;
			int m;
			slot = -1;
			n = 0;
			if (v <= floor_vol || dl < 5) return 0;
			for (int i = 0; i < Cap; i++)
				if (held[i] && held_key[i] == k) begin
					if (v > held_vol[i]) begin
						held_vol[i] = v;
						return 1;
					end
					return 0;
				end
			for (int i = 0; i < Cap; i++)
				if (held[i] && held_vol[i] == v) return 0;
			for (int i = 0; i < Cap; i++)
				if (!held[i] && slot < 0) slot = i;
			if (slot >= 0) begin
				held[slot] = 1;
				held_key[slot] = k;
				held_vol[slot] = v;
			end else begin
				m = smallest_slot();
				if (m >= 0 && v > held_vol[m]) begin
					held_key[m] = k;
					held_vol[m] = v;
				end
			end
			lim = keep_lim < Cap ? keep_lim : Cap;
			foreach (held[i]) n += held[i];
			while (n > lim) begin
				held[smallest_slot()] = 0;
				n--;
			end
			return 1;
		endfunction

		function void note_item(cmd_t c, bit [30:0] v, bit [31:0] k, bit [7:0] dl);
			int m;
			bit a;
			a = 0;
			case (c)
				CMD_INSERT: a = insert_entry(v, k, dl);
				CMD_QUERY: begin
					m = smallest_slot();
					a = m >= 0 && held_vol[m] <= v;
				end
				CMD_CLEAR: foreach (held[i]) held[i] = 0;
				default: a = 0;
			endcase
			answers.push_back(a);
		endfunction

		task check_answer(bit got);
			if (answers.size() == 0) begin
				report("answer with no transaction pending");
				return;
			end
			if (answers[0] !== got)
				report($sformatf("answer %0b, predicted %0b", got, answers[0]));
			void'(answers.pop_front());
		endtask

		task report(string msg);
			$display("mismatch at %0t: %s", $time, msg);
			errors++;
		endtask
	endclass

	logic clk = 0, arst_n = 0;
	logic in_valid = 0, out_stall = 0, cfg_valid = 0, cfg_index = 0;
	logic [1:0] command = 0;
	logic [30:0] volume = 0;
	logic [31:0] period_key = 0, cfg_data = 0;
	logic [7:0] date_length = 0;
	logic in_stall, out_valid, answer, cfg_ready;
	table_scoreboard sb = new();
	bit quiet = 0;
	bit hold_long = 0;

	top_k_per_key_max_table #(.CAPACITY(Cap)) dut (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// receiver: random stall bursts, one long hold-off on request
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_answer(answer);
	end
	initial begin
		wait (arst_n);
		forever begin
			if (hold_long) begin
				out_stall <= 1;
				repeat (400) @(posedge clk);
				hold_long = 0;
			end
			out_stall <= (!quiet && $urandom_range(3) == 0);
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	end

	task automatic send_item(cmd_t c, bit [30:0] v, bit [31:0] k, bit [7:0] dl);
		if (!quiet && $urandom_range(3) == 0) begin
			in_valid <= 0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		in_valid <= 1;
		command <= c;
		volume <= v;
		period_key <= k;
		date_length <= dl;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_item(c, v, k, dl);
	endtask

	task automatic write_reg(logic idx, bit [31:0] d);
		in_valid <= 0;
		while (sb.answers.size() != 0) @(posedge clk);
		// evictions finish before their answer; this wait is only a margin
		repeat (Cap * (Cap + 2) + 40) @(posedge clk);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 0;
		if (idx == CfgMinVolume) sb.floor_vol = d[30:0];
		else sb.keep_lim = d[4:0];
	endtask

	function automatic cmd_t pick_cmd();
		int r;
		r = $urandom_range(99);
		if (r < 70) return CMD_INSERT;
		if (r < 92) return CMD_QUERY;
		if (r < 97) return CMD_CLEAR;
		return CMD_NONE;
	endfunction

	task automatic random_phase(int count, int vol_span);
		bit [30:0] v;
		for (int i = 0; i < count; i++) begin
			v = ($urandom_range(7) == 0) ? 31'($urandom) : 31'($urandom_range(vol_span));
			send_item(pick_cmd(), v, ($urandom_range(1) ? 32'($urandom) : 32'h3230_3200)
				| 32'($urandom_range(23)), ($urandom_range(9) == 0) ? 8'($urandom_range(4))
				: 8'($urandom_range(5, 255)));
		end
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// directed: extremes and special cases
		send_item(CMD_QUERY, 31'h7fffffff, 0, 0);
		send_item(CMD_INSERT, 31'h7fffffff, 32'hffffffff, 8'hff);
		send_item(CMD_INSERT, 0, 0, 8'hff);
		send_item(CMD_INSERT, 10, 1, 4);
		send_item(CMD_INSERT, 10, 1, 5);
		send_item(CMD_INSERT, 20, 1, 5);
		send_item(CMD_INSERT, 15, 1, 5);
		send_item(CMD_INSERT, 20, 2, 5);
		send_item(CMD_INSERT, 30, 3, 5);
		send_item(CMD_INSERT, 20, 3, 5);
		send_item(CMD_QUERY, 19, 0, 0);
		send_item(CMD_QUERY, 20, 0, 0);
		send_item(CMD_NONE, 50, 7, 9);
		send_item(CMD_CLEAR, 31'h7fffffff, 32'hffffffff, 8'hff);
		send_item(CMD_QUERY, 31'h7fffffff, 0, 0);
		for (int i = 0; i < 18; i++) send_item(CMD_INSERT, 31'(100 + i * 3), i, 6);
		send_item(CMD_INSERT, 1, 99, 6);
		write_reg(CfgKeepCount, 0);
		send_item(CMD_INSERT, 500, 5, 6);
		send_item(CMD_QUERY, 0, 0, 0);
		write_reg(CfgKeepCount, 3);
		write_reg(CfgMinVolume, 31'h7ffffff0);
		for (int i = 0; i < 6; i++) send_item(CMD_INSERT, 31'h7fffffff - 31'(i), i, 8);
		write_reg(CfgMinVolume, 0);
		// long receiver hold-off while the sender keeps going
		hold_long = 1;
		random_phase(40, 200);
		write_reg(CfgKeepCount, 31);
		write_reg(CfgMinVolume, 50);
		random_phase(250, 300);
		write_reg(CfgKeepCount, 16);
		write_reg(CfgMinVolume, 31'h7fffffff);
		random_phase(30, 300);
		write_reg(CfgMinVolume, 0);
		write_reg(CfgKeepCount, 5);
		random_phase(250, 100);
		write_reg(CfgKeepCount, 16);
		quiet = 1;
		random_phase(150, 500);
		in_valid <= 0;
		while (sb.answers.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (sb.errors == 0)
			$display("** top_k_per_key_max_table: PASSED **");
		else
			$display("** top_k_per_key_max_table: FAILED **");
		$finish;
	end

	initial begin
		#20ms;
		$display("** top_k_per_key_max_table: FAILED **");
		$finish;
	end
endmodule
